// ===== hw/rtl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and constants for the bank-switch mapper
// Command codes, result targets, register decode codes and channel payloads.
// ----------------------------------------------------------------------------
package bsm_pkg;

  typedef enum logic [2:0] {
    CMD_REG_WRITE     = 3'd0,
    CMD_SCRATCH_WRITE = 3'd1,
    CMD_LOW_READ      = 3'd2,
    CMD_CPU_TICKS     = 3'd3,
    CMD_SCANLINE      = 3'd4,
    CMD_SOFT_RESET    = 3'd5,
    CMD_CPU_MAP       = 3'd6,
    CMD_PPU_MAP       = 3'd7
  } cmd_e;

  localparam logic [1:0] TGT_PRG_ROM  = 2'd0;
  localparam logic [1:0] TGT_PRG_RAM  = 2'd1;
  localparam logic [1:0] TGT_CHR_ROM  = 2'd2;
  localparam logic [1:0] TGT_UNMAPPED = 2'd3;

  localparam logic [1:0] CFG_ALT_WIRING    = 2'd0;
  localparam logic [1:0] CFG_BOARD_VARIANT = 2'd1;
  localparam logic [1:0] CFG_WRAM_PRESENT  = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 2;

  // decode of address bits {9, 8, 4, 3} after the wiring scramble
  localparam logic [3:0] SEL_PRG_A   = 4'b1100;
  localparam logic [3:0] SEL_PRG_B   = 4'b1101;
  localparam logic [3:0] SEL_CHR     = 4'b1110;
  localparam logic [3:0] SEL_SCANCFG = 4'b1111;

  localparam logic [1:0] BOARD_VAR_WRAM  = 2'd2;
  localparam logic [1:0] BOARD_VAR_NARROW = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
  } in_payload_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_pending;
    logic [11:0] bank;
    logic [1:0]  target;
    logic        write_enable;
    logic [1:0]  mirroring;
  } out_payload_t;

endpackage

// ===== hw/rtl/bsm_in_if.sv =====
// ----------------------------------------------------------------------------
// bsm_in_if: bus transaction channel into the mapper
// Valid/ready handshake carrying command, address and data.
// ----------------------------------------------------------------------------
interface bsm_in_if;
  logic                valid;
  logic                ready;
  bsm_pkg::in_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bsm_out_if.sv =====
// ----------------------------------------------------------------------------
// bsm_out_if: result channel out of the mapper
// Valid/ready handshake carrying read data, IRQ level, bank translation, write enable and mirroring.
// ----------------------------------------------------------------------------
interface bsm_out_if;
  logic                 valid;
  logic                 ready;
  bsm_pkg::out_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bank_switch_mapper_with_irq_counter.sv =====
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_irq_counter: cartridge bank-switch chip with IRQ
// Register writes, scratch RAM, DIP reads, 16-bit up/down IRQ counter and
// CPU/PPU address translation; one result per bus transaction.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | handshake
//  in_i    | in  | cmd, addr, data                                | valid/ready
//  out_o   | out | read_data, irq_pending, bank, target, we, mirr | valid/ready
//  cfg     | in  | cfg_idx_i, cfg_data_i                          | cfg_we_i
//
//  One transaction per cycle while results are taken; each transaction is held in
//  the input register, then state update and result register follow in one pass.
//  rst_ni clears all mapper state, scratch RAM, DIP value and configuration.
//  A stalled result holds; the input register still takes one more transaction.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_irq_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bsm_pkg::CfgDataW-1:0]  cfg_data_i,
  bsm_in_if.sink                        in_i,
  bsm_out_if.source                     out_o
);
  import bsm_pkg::*;

  logic         alt_q;
  logic [1:0]   variant_q;
  logic         wram_q;

  logic         in_valid_q;
  in_payload_t  in_q;
  logic         out_valid_q;
  out_payload_t out_q;
  out_payload_t out_d;
  logic         advance;

  logic [7:0]   regs_q [16];
  logic [7:0]   regs_d [16];
  logic [7:0]   scratch_q [4];
  logic [7:0]   scratch_d [4];
  logic         counting_q, counting_d;
  logic         scan_q, scan_d;
  logic [7:0]   dip_q, dip_d;
  logic         irq_q, irq_d;

  cmd_e         cmd;
  logic [15:0]  a;
  logic [15:0]  a_sc;
  logic [3:0]   sel;
  logic [15:0]  cnt;
  logic [16:0]  n;
  logic [16:0]  sum;
  logic [16:0]  diff;
  logic         fire;
  logic [15:0]  cnt_next;
  logic         adv_en;
  logic [3:0]   rd_idx;
  logic [7:0]   rd_val;
  logic [4:0]   mask;
  logic [7:0]   r0;
  logic [7:0]   b16;
  logic [8:0]   maskx;
  logic [8:0]   low9;
  logic [2:0]   slot;

  // --- handshake ------------------------------------------------------------
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_q     <= 1'b0;
      variant_q <= 2'd0;
      wram_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALT_WIRING:    alt_q     <= cfg_data_i[0];
        CFG_BOARD_VARIANT: variant_q <= cfg_data_i[1:0];
        CFG_WRAM_PRESENT:  wram_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // --- mapper state ---------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) regs_q[i] <= 8'd0;
      for (int i = 0; i < 4; i++) scratch_q[i] <= 8'd0;
      counting_q <= 1'b0;
      scan_q     <= 1'b0;
      dip_q      <= 8'd0;
      irq_q      <= 1'b0;
    end else if (advance) begin
      regs_q     <= regs_d;
      scratch_q  <= scratch_d;
      counting_q <= counting_d;
      scan_q     <= scan_d;
      dip_q      <= dip_d;
      irq_q      <= irq_d;
    end
  end

  // --- shared operand logic -------------------------------------------------
  assign cmd  = cmd_e'(in_q.cmd);
  assign a    = in_q.addr;
  assign a_sc = alt_q ? {2'b00, a[15:8], a[5:0]} : a;
  assign sel  = {a_sc[9], a_sc[8], a_sc[4], a_sc[3]};
  assign r0   = regs_q[0];
  assign slot = a[12:10];
  assign mask = (alt_q || variant_q == BOARD_VAR_NARROW) ? 5'h0F : 5'h1F;

  assign cnt      = {regs_q[3], regs_q[2]};
  assign n        = (cmd == CMD_SCANLINE) ? 17'd8 : {9'd0, in_q.data};
  assign sum      = {1'b0, cnt} + n;
  assign diff     = {1'b0, cnt} - n;
  assign fire     = regs_q[1][6] ? (diff[16] || diff[15:0] == 16'd0) : sum[16];
  assign cnt_next = fire ? 16'd0 : (regs_q[1][6] ? diff[15:0] : sum[15:0]);
  assign adv_en   = counting_q && cnt != 16'd0 && n != 17'd0;

  always_comb begin
    if (cmd == CMD_CPU_MAP) begin
      rd_idx = a[15] ? {2'b01, a[14:13]} : 4'd7;
    end else if (alt_q || variant_q == 2'd1) begin
      rd_idx = {1'b1, slot[2], slot[2], slot[1]};
    end else begin
      rd_idx = {1'b1, slot};
    end
  end
  assign rd_val = regs_q[rd_idx];

  assign b16   = a[14] ? (r0 | {4'd0, mask[4:1]}) : r0;
  assign maskx = {4'd0, mask};
  assign low9  = (a[14:13] == 2'b11) ? 9'h0FF : {1'b0, rd_val};

  // --- next state and result ------------------------------------------------
  always_comb begin
    regs_d     = regs_q;
    scratch_d  = scratch_q;
    counting_d = counting_q;
    scan_d     = scan_q;
    dip_d      = dip_q;
    irq_d      = irq_q;
    out_d      = '0;
    out_d.target = TGT_UNMAPPED;

    unique case (cmd)
      CMD_REG_WRITE: begin
        if (a[15]) begin
          unique case (sel)
            SEL_PRG_A, SEL_PRG_B: regs_d[{2'b01, a_sc[1:0]}] = in_q.data;
            SEL_CHR:              regs_d[{1'b1, a_sc[2:0]}] = in_q.data;
            SEL_SCANCFG:          scan_d = in_q.data[6];
            default: begin
              if (a_sc[9]) begin
                regs_d[{3'b001, a_sc[0]}] = in_q.data;
                if (a_sc[0]) begin
                  counting_d = regs_q[1][7];
                end else begin
                  irq_d = 1'b0;
                end
              end else begin
                regs_d[{3'b000, a_sc[8]}] = in_q.data;
              end
            end
          endcase
        end
      end
      CMD_SCRATCH_WRITE: begin
        if (a[15:12] == 4'h5) scratch_d[a[1:0]] = in_q.data;
      end
      CMD_LOW_READ: begin
        if (a[15:12] == 4'h5) begin
          if (alt_q ? a[10] : a[8]) begin
            out_d.read_data = scratch_q[a[1:0]];
          end else begin
            out_d.read_data = dip_q;
          end
        end
      end
      CMD_CPU_TICKS, CMD_SCANLINE: begin
        if (((cmd == CMD_CPU_TICKS) != scan_q) && adv_en) begin
          regs_d[2] = cnt_next[7:0];
          regs_d[3] = cnt_next[15:8];
          if (fire) begin
            irq_d      = 1'b1;
            counting_d = 1'b0;
          end
        end
      end
      CMD_SOFT_RESET: begin
        for (int i = 0; i < 16; i++) regs_d[i] = 8'd0;
        dip_d = dip_q + 8'd1;
        irq_d = 1'b0;
      end
      CMD_CPU_MAP: begin
        if (a[15]) begin
          out_d.target = TGT_PRG_ROM;
          case (regs_q[1][4:3])
            2'b00:   out_d.bank = {3'd0, b16, a[13]};
            2'b01:   out_d.bank = {3'd0, r0, a[13]};
            default: out_d.bank = {3'd0, ({r0, 1'b0} & ~maskx) | (low9 & maskx)};
          endcase
        end else if (a[14:13] == 2'b11) begin
          if (variant_q == BOARD_VAR_WRAM && wram_q) begin
            out_d.bank   = {10'd0, r0[7:6]};
            out_d.target = TGT_PRG_RAM;
          end else begin
            out_d.bank   = {4'd0, rd_val};
            out_d.target = TGT_PRG_ROM;
          end
        end
      end
      CMD_PPU_MAP: begin
        if (a[15:13] == 3'd0) begin
          out_d.target = TGT_CHR_ROM;
          if (alt_q) begin
            out_d.bank = {3'd0, rd_val, slot[0]};
          end else begin
            case (variant_q)
              2'd0:    out_d.bank = {4'd0, rd_val};
              2'd1:    out_d.bank = {3'd0, rd_val, slot[0]};
              2'd2:    out_d.bank = {r0[7:4], rd_val};
              default: out_d.bank = {2'd0, r0[7:6], rd_val};
            endcase
          end
        end
      end
      default: ;
    endcase

    out_d.irq_pending  = irq_d;
    out_d.write_enable = (variant_q == BOARD_VAR_WRAM) || regs_d[1][5];
    out_d.mirroring    = regs_d[1][1:0];
  end

  // --- checks ---------------------------------------------------------------
  a_irq_rise_on_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_q) |-> $past(advance && (cmd == CMD_CPU_TICKS || cmd == CMD_SCANLINE)))
    else $error("IRQ raised outside a counter advance");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result produced without a held transaction");

  a_soft_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cmd == CMD_SOFT_RESET |=> regs_q[1] == 8'd0 && !irq_q && !out_q.irq_pending)
    else $error("soft reset left mapper state set");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bank_switch_mapper_with_irq_counter
// Drives bus transactions through the input channel under several board
// settings, predicts each result from a local copy of the mapper state, and
// compares every result field against the prediction in order.
// ----------------------------------------------------------------------------
module testbench;
  import bsm_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned ItemsPerBoard = 130;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bsm_in_if in_bus ();
  bsm_out_if out_bus ();

  bank_switch_mapper_with_irq_counter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mapper state as seen by the bench
  logic [7:0] map_regs [16];
  logic [7:0] scratch [4];
  logic cnt_run, line_mode, irq_hold;
  logic [7:0] dip;
  logic cfg_alt, cfg_wram;
  logic [1:0] cfg_variant;

  in_payload_t bus_q [$];
  out_payload_t owed_results [$];
  out_payload_t want;

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned irq_raises = 0;
  int unsigned boards_run = 0;
  int unsigned fails = 0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  int unsigned idle_cycles = 0;

  function automatic void reg_write(logic [15:0] a_in, logic [7:0] v);
    logic [15:0] a;
    a = a_in;
    if (cfg_alt) a = ((a_in >> 2) & ~16'h003F) | (a_in & 16'h003F);
    case ({a[9], a[8], a[4], a[3]})
      SEL_PRG_A, SEL_PRG_B: map_regs[{2'b01, a[1:0]}] = v;
      SEL_CHR: map_regs[{1'b1, a[2:0]}] = v;
      SEL_SCANCFG: line_mode = v[6];
      default: begin
        if (a[9]) begin
          map_regs[{3'b001, a[0]}] = v;
          if (a[0]) cnt_run = map_regs[1][7];
          else irq_hold = 1'b0;
        end else begin
          map_regs[{3'b000, a[8]}] = v;
        end
      end
    endcase
  endfunction

  function automatic void count_ticks(int unsigned n);
    int unsigned c;
    logic fire;
    c = {map_regs[3], map_regs[2]};
    fire = 1'b0;
    if (!cnt_run || c == 0 || n == 0) return;
    if (map_regs[1][6]) begin
      if (n >= c) begin
        c = 0;
        fire = 1'b1;
      end else c = c - n;
    end else begin
      if (n >= 32'h10000 - c) begin
        c = 0;
        fire = 1'b1;
      end else c = c + n;
    end
    if (fire) begin
      irq_hold = 1'b1;
      cnt_run = 1'b0;
      irq_raises++;
    end
    map_regs[2] = c[7:0];
    map_regs[3] = c[15:8];
  endfunction

  function automatic out_payload_t mapper_step(in_payload_t t);
    out_payload_t r;
    int unsigned mask, r0, half, b16, slot, low, bk, pick;
    logic [15:0] a;
    r = '0;
    r.target = TGT_UNMAPPED;
    a = t.addr;
    r0 = map_regs[0];
    bk = 0;
    case (cmd_e'(t.cmd))
      CMD_REG_WRITE: if (a >= 16'h8000) reg_write(a, t.data);
      CMD_SCRATCH_WRITE: if (a >= 16'h5000 && a < 16'h6000) scratch[a[1:0]] = t.data;
      CMD_LOW_READ: begin
        if (a >= 16'h5000 && a < 16'h6000) begin
          if (cfg_alt ? a[10] : a[8]) r.read_data = scratch[a[1:0]];
          else r.read_data = dip;
        end
      end
      CMD_CPU_TICKS: if (!line_mode) count_ticks(t.data);
      CMD_SCANLINE: if (line_mode) count_ticks(8);
      CMD_SOFT_RESET: begin
        foreach (map_regs[i]) map_regs[i] = 8'h00;
        dip = dip + 8'd1;
        irq_hold = 1'b0;
      end
      CMD_CPU_MAP: begin
        mask = (cfg_alt || cfg_variant == BOARD_VAR_NARROW) ? 32'h0F : 32'h1F;
        if (a >= 16'h8000) begin
          half = a[13];
          case (map_regs[1] & 8'h18)
            8'h00: begin
              b16 = a[14] ? (r0 | (mask >> 1)) : r0;
              bk = (b16 << 1) | half;
            end
            8'h08: bk = (r0 << 1) | half;
            default: begin
              slot = a[14:13];
              low = (slot == 3) ? 32'hFF : map_regs[4 + slot];
              bk = ((r0 << 1) & ~mask) | (low & mask);
            end
          endcase
          r.target = TGT_PRG_ROM;
        end else if (a >= 16'h6000) begin
          if (cfg_variant == BOARD_VAR_WRAM && cfg_wram) begin
            bk = r0 >> 6;
            r.target = TGT_PRG_RAM;
          end else begin
            bk = map_regs[7];
            r.target = TGT_PRG_ROM;
          end
        end
      end
      default: begin
        slot = a[12:10];
        if (a < 16'h2000) begin
          if (cfg_alt || cfg_variant == 2'd1) begin
            case (slot[2:1])
              2'd0: pick = 8;
              2'd1: pick = 9;
              2'd2: pick = 14;
              default: pick = 15;
            endcase
            bk = (map_regs[pick] << 1) | slot[0];
          end else if (cfg_variant == 2'd0) begin
            bk = map_regs[8 + slot];
          end else if (cfg_variant == BOARD_VAR_WRAM) begin
            bk = ((r0 << 4) & ~32'hFF) | map_regs[8 + slot];
          end else begin
            bk = ((r0 << 2) & ~32'hFF) | map_regs[8 + slot];
          end
          r.target = TGT_CHR_ROM;
        end
      end
    endcase
    r.bank = bk[11:0];
    r.irq_pending = irq_hold;
    r.write_enable = (cfg_variant == BOARD_VAR_WRAM) || map_regs[1][5];
    r.mirroring = map_regs[1][1:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic check_field(string name, logic [11:0] want_v, logic [11:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      fails++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        owed_results.push_back(mapper_step(in_bus.payload));
        items_taken++;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 59) == 0) calm_left = $urandom_range(20, 60);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (bus_q.size() != 0) begin
          in_bus.payload <= bus_q.pop_front();
          in_bus.valid <= 1'b1;
          if (calm_left == 0) in_gap = pick_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          $error("result transaction with no prediction pending");
          fails++;
        end else begin
          want = owed_results.pop_front();
          check_field("read_data", want.read_data, out_bus.payload.read_data);
          check_field("irq_pending", want.irq_pending, out_bus.payload.irq_pending);
          check_field("bank", want.bank, out_bus.payload.bank);
          check_field("target", want.target, out_bus.payload.target);
          check_field("write_enable", want.write_enable, out_bus.payload.write_enable);
          check_field("mirroring", want.mirroring, out_bus.payload.mirroring);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (calm_left == 0 && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(cmd_e c, logic [15:0] a, logic [7:0] d);
    in_payload_t t;
    t.cmd = c;
    t.addr = a;
    t.data = d;
    bus_q.push_back(t);
    items_queued++;
  endtask

  // bus address hitting mapper register r (16 selects the scanline config)
  function automatic logic [15:0] reg_bus_addr(int unsigned r);
    logic [15:0] base, spare;
    if (r <= 1) base = r[0] ? 16'h0100 : 16'h0000;
    else if (r <= 3) base = 16'h0200 | r[0];
    else if (r <= 7) base = 16'h0300 | r[1:0];
    else if (r <= 15) base = 16'h0310 | r[2:0];
    else base = 16'h0318;
    spare = $urandom;
    if (cfg_alt) return 16'h8000 | ((base & 16'h0300) << 2) | (base & 16'h003F) | (spare & 16'h73C0);
    return 16'h8000 | base | (spare & 16'h7CE0);
  endfunction

  function automatic logic [15:0] window_addr();
    if ($urandom_range(0, 6) == 0) return $urandom;
    return 16'h5000 | $urandom_range(0, 16'h0FFF);
  endfunction

  task automatic push_counter_run();
    logic [7:0] ctl, hi;
    int unsigned n;
    ctl = $urandom;
    if ($urandom_range(0, 4) != 0) ctl[7] = 1'b1;
    if (ctl[6]) hi = ($urandom_range(0, 3) == 0) ? $urandom : 8'h00;
    else hi = ($urandom_range(0, 3) == 0) ? 8'hFE : 8'hFF;
    push_item(CMD_REG_WRITE, reg_bus_addr(1), ctl);
    push_item(CMD_REG_WRITE, reg_bus_addr(2), $urandom_range(0, 60));
    push_item(CMD_REG_WRITE, reg_bus_addr(3), hi);
    if ($urandom_range(0, 2) == 0) push_item(CMD_REG_WRITE, reg_bus_addr(16), $urandom);
    n = $urandom_range(2, 8);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) begin
        push_item(CMD_CPU_TICKS, $urandom,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 24));
      end else begin
        push_item(CMD_SCANLINE, $urandom, $urandom);
      end
    end
  endtask

  task automatic push_random_item();
    int unsigned pick;
    logic [15:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      if ($urandom_range(0, 4) == 0) a = $urandom;
      else a = reg_bus_addr($urandom_range(0, 16));
      push_item(CMD_REG_WRITE, a, $urandom);
    end else if (pick < 32) begin
      push_item(CMD_SCRATCH_WRITE, window_addr(), $urandom);
    end else if (pick < 44) begin
      push_item(CMD_LOW_READ, window_addr(), $urandom);
    end else if (pick < 54) begin
      push_item(CMD_CPU_TICKS, $urandom, $urandom);
    end else if (pick < 62) begin
      push_item(CMD_SCANLINE, $urandom, $urandom);
    end else if (pick < 65) begin
      push_item(CMD_SOFT_RESET, $urandom, $urandom);
    end else if (pick < 83) begin
      case ($urandom_range(0, 3))
        0, 1: a = 16'h8000 | $urandom_range(0, 16'h7FFF);
        2: a = 16'h6000 | $urandom_range(0, 16'h1FFF);
        default: a = $urandom;
      endcase
      push_item(CMD_CPU_MAP, a, $urandom);
    end else begin
      if ($urandom_range(0, 4) == 0) a = $urandom;
      else a = $urandom_range(0, 16'h1FFF);
      push_item(CMD_PPU_MAP, a, $urandom);
    end
  endtask

  task automatic push_random_items(int unsigned quota);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < quota) begin
      if ($urandom_range(0, 3) == 0) push_counter_run();
      else push_random_item();
    end
  endtask

  task automatic drain();
    while (bus_q.size() != 0 || in_bus.valid || owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_board(logic alt, logic [1:0] variant, logic wram);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ALT_WIRING;
    cfg_data_i <= {1'b0, alt};
    @(posedge clk_i);
    cfg_idx_i <= CFG_BOARD_VARIANT;
    cfg_data_i <= variant;
    @(posedge clk_i);
    cfg_idx_i <= CFG_WRAM_PRESENT;
    cfg_data_i <= {1'b0, wram};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_alt = alt;
    cfg_variant = variant;
    cfg_wram = wram;
    boards_run++;
  endtask

  initial begin
    logic [3:0] boards [8];
    boards = '{4'b0_00_0, 4'b0_01_1, 4'b0_10_1, 4'b0_10_0,
               4'b0_11_0, 4'b1_00_0, 4'b1_11_1, 4'b1_10_1};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_bus.valid = 1'b0;
    in_bus.payload = '0;
    out_bus.ready = 1'b0;
    foreach (map_regs[i]) map_regs[i] = 8'h00;
    foreach (scratch[i]) scratch[i] = 8'h00;
    cnt_run = 1'b0;
    line_mode = 1'b0;
    irq_hold = 1'b0;
    dip = 8'h00;
    cfg_alt = 1'b0;
    cfg_variant = 2'd0;
    cfg_wram = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_board(1'b0, 2'd0, 1'b0);
    // ignored write, counter stuck at zero, fire, scanline mode, window edges
    push_item(CMD_REG_WRITE, 16'h7FFF, 8'hFF);
    push_item(CMD_REG_WRITE, 16'h8100, 8'hC3);
    push_item(CMD_REG_WRITE, 16'h8000, 8'hFF);
    push_item(CMD_REG_WRITE, 16'h8200, 8'h00);
    push_item(CMD_REG_WRITE, 16'h8201, 8'h00);
    push_item(CMD_CPU_TICKS, 16'h0000, 8'hFF);
    push_item(CMD_REG_WRITE, 16'h8200, 8'h05);
    push_item(CMD_CPU_TICKS, 16'hFFFF, 8'hFF);
    push_item(CMD_REG_WRITE, 16'h8318, 8'h40);
    push_item(CMD_REG_WRITE, 16'h8201, 8'h01);
    push_item(CMD_CPU_TICKS, 16'h0000, 8'h10);
    push_item(CMD_SCANLINE, 16'hFFFF, 8'h00);
    push_item(CMD_REG_WRITE, 16'h8318, 8'h00);
    push_item(CMD_REG_WRITE, 16'h8310, 8'hFF);
    push_item(CMD_REG_WRITE, 16'h8307, 8'hAB);
    push_item(CMD_SCRATCH_WRITE, 16'h5FFF, 8'hFF);
    push_item(CMD_SCRATCH_WRITE, 16'h4FFF, 8'h12);
    push_item(CMD_LOW_READ, 16'h5103, 8'h00);
    push_item(CMD_LOW_READ, 16'h5000, 8'h00);
    push_item(CMD_CPU_MAP, 16'h5FFF, 8'h00);
    push_item(CMD_CPU_MAP, 16'h6000, 8'h00);
    push_item(CMD_CPU_MAP, 16'h8000, 8'h00);
    push_item(CMD_CPU_MAP, 16'hFFFF, 8'h00);
    push_item(CMD_PPU_MAP, 16'h0000, 8'h00);
    push_item(CMD_PPU_MAP, 16'h2000, 8'h00);
    push_item(CMD_SOFT_RESET, 16'h0000, 8'h00);
    push_item(CMD_LOW_READ, 16'h5000, 8'h00);
    push_random_items(ItemsPerBoard);

    for (int b = 1; b < 8; b++) begin
      drain();
      set_board(boards[b][3], boards[b][2:1], boards[b][0]);
      push_random_items(ItemsPerBoard);
    end
    drain();

    $display("Ran %0d bus transactions, %0d results checked, across %0d board settings;",
             items_taken, results_seen, boards_run);
    $display("the IRQ counter fired %0d times.", irq_raises);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
